FILE: design/ccgc_pkg.sv
package ccgc_pkg;

   localparam int MEM_DEPTH = 1024;
   localparam int REG_COUNT = 32;

   localparam int IDX_W     = $clog2(MEM_DEPTH);
   localparam int CNT_W     = $clog2(MEM_DEPTH + 1);
   localparam int REG_W     = $clog2(REG_COUNT);
   localparam int ADDR_W    = IDX_W + 1;
   localparam int MEM_WORDS = 2 ** ADDR_W;

   localparam int TAG_W   = 4;
   localparam int PAY_W   = 32;
   localparam int WORD_W  = TAG_W + PAY_W;
   localparam int RNUM_W  = 5;
   localparam int FUNC_W  = 4;
   localparam int STAT_W  = 2;
   localparam int CELLS_W = 11;

   localparam logic [TAG_W-1:0] TAG_NULL   = 4'h0;
   localparam logic [TAG_W-1:0] TAG_PAIR   = 4'h1;
   localparam logic [TAG_W-1:0] TAG_BROKEN = 4'h5;
   localparam logic [TAG_W-1:0] TAG_MAX    = 4'hA;

   localparam logic [FUNC_W-1:0] FN_WRITE_IMM = 4'd0;
   localparam logic [FUNC_W-1:0] FN_COPY      = 4'd1;
   localparam logic [FUNC_W-1:0] FN_CONS      = 4'd2;
   localparam logic [FUNC_W-1:0] FN_CAR       = 4'd3;
   localparam logic [FUNC_W-1:0] FN_CDR       = 4'd4;
   localparam logic [FUNC_W-1:0] FN_SET_CAR   = 4'd5;
   localparam logic [FUNC_W-1:0] FN_SET_CDR   = 4'd6;
   localparam logic [FUNC_W-1:0] FN_READ      = 4'd7;
   localparam logic [FUNC_W-1:0] FN_COLLECT   = 4'd8;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_PAIR = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_MEM   = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_IMM  = 2'd3;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [PAY_W-1:0] pay;
   } word_type;

   typedef enum logic [4:0] {
      U_NONE, U_ACCEPT, U_IMM, U_RD_A, U_RD_B, U_COPY, U_CAR_RD, U_CAR_WB,
      U_SET, U_CONS, U_FULL, U_GC_INIT, U_GC_RDREG, U_GC_LDREG, U_GC_RDCELL,
      U_GC_LDCELL, U_F_RD, U_F_EVAL, U_F_MARK, U_WB_REG, U_WB_FIRST,
      U_WB_SECOND, U_GC_FLIP, U_DONE
   } uop_type;

   typedef struct packed {
      uop_type uop;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              rd_pair;
      logic              a_pair;
      logic              broken;
      logic              full;
      logic              scan_regs;
      logic              scan_done;
      logic              out_free;
   } sts_type;

   function automatic logic is_pair(input word_type w);
      return (w.tag == TAG_PAIR) && (w.pay < 32'(MEM_DEPTH));
   endfunction

   function automatic word_type pair_word(input logic [CNT_W-1:0] idx);
      word_type w;
      w.tag = TAG_PAIR;
      w.pay = 32'(idx);
      return w;
   endfunction

   function automatic logic [IDX_W-1:0] cell_idx(input logic [PAY_W-1:0] pay);
      return pay[IDX_W-1:0];
   endfunction

   function automatic logic [REG_W-1:0] reg_idx(input logic [RNUM_W-1:0] r);
      logic [REG_W+RNUM_W-1:0] t;
      t = {{REG_W{1'b0}}, r};
      return t[REG_W-1:0];
   endfunction

   function automatic logic reg_ok(input logic [RNUM_W-1:0] r);
      return 32'(r) < REG_COUNT;
   endfunction

   function automatic logic [CELLS_W-1:0] cells_of(input logic [CNT_W-1:0] f);
      logic [CNT_W+CELLS_W-1:0] t;
      t = {{CELLS_W{1'b0}}, f};
      return t[CELLS_W-1:0];
   endfunction

endpackage

FILE: design/cons_cell_store_with_copying_gc.sv
// Path from the accepting edge to rsp_valid: write_imm and unused codes finish from dispatch;
// copy, read and a car/cdr on a non-pair add a register read; car, cdr, set_car, set_cdr and
// cons add a second read and a write. A collect, or a cons on a full space, adds a Cheney walk
// over the registers, then over each live cell; one registered read per RAM per cycle, so every
// forward is a read, a check and a write. Only one item is in flight; a new request is taken
// only after the last one has posted its response. Reset: synchronous, active high; registers
// read as null via valid bits, free pointer = register count, semispace 0 active.
module cons_cell_store_with_copying_gc (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ccgc_pkg::FUNC_W-1:0]   req_func,
   input  logic [ccgc_pkg::RNUM_W-1:0]   req_dest_reg,
   input  logic [ccgc_pkg::RNUM_W-1:0]   req_src_a_reg,
   input  logic [ccgc_pkg::RNUM_W-1:0]   req_src_b_reg,
   input  logic [ccgc_pkg::TAG_W-1:0]    req_imm_tag,
   input  logic [ccgc_pkg::PAY_W-1:0]    req_imm_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ccgc_pkg::TAG_W-1:0]    rsp_value_tag,
   output logic [ccgc_pkg::PAY_W-1:0]    rsp_value_payload,
   output logic [ccgc_pkg::STAT_W-1:0]   rsp_status,
   output logic [ccgc_pkg::CELLS_W-1:0]  rsp_cells_used,
   output logic                          rsp_gc_ran
);
   import ccgc_pkg::*;

   // controller sequences micro-ops; datapath owns all storage
   cmd_type cmd;
   sts_type sts;

   ccgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // registers live in their own small RAM; cell halves in two RAMs
   // addressed {semispace, index}
   ccgc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_dest_reg      (req_dest_reg),
      .req_src_a_reg     (req_src_a_reg),
      .req_src_b_reg     (req_src_b_reg),
      .req_imm_tag       (req_imm_tag),
      .req_imm_payload   (req_imm_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value_tag     (rsp_value_tag),
      .rsp_value_payload (rsp_value_payload),
      .rsp_status        (rsp_status),
      .rsp_cells_used    (rsp_cells_used),
      .rsp_gc_ran        (rsp_gc_ran)
   );

   // error results carry no object
   a_err_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_value_tag == TAG_NULL) && (rsp_value_payload == '0))
      else $error("error result carries a value");

   // out of memory is only reported after a collection
   a_oom_after_gc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NO_MEM) |-> rsp_gc_ran)
      else $error("out of memory without collection");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a second item while busy");

endmodule

FILE: design/ccgc_ram.sv
module ccgc_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/ccgc_ctrl.sv
module ccgc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ccgc_pkg::sts_type sts,
   output ccgc_pkg::cmd_type cmd
);
   import ccgc_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE      = 15'b000000000000001,
      S_DISPATCH  = 15'b000000000000010,
      S_A         = 15'b000000000000100,
      S_B         = 15'b000000000001000,
      S_CAR_WB    = 15'b000000000010000,
      S_GC_INIT   = 15'b000000000100000,
      S_GC_NEXT   = 15'b000000001000000,
      S_GC_LDREG  = 15'b000000010000000,
      S_GC_LDCELL = 15'b000000100000000,
      S_F_CHK     = 15'b000001000000000,
      S_F_EVAL    = 15'b000010000000000,
      S_F_MARK    = 15'b000100000000000,
      S_WB        = 15'b001000000000000,
      S_AFTER_GC  = 15'b010000000000000,
      S_FINISH    = 15'b100000000000000
   } state_type;

   typedef enum logic [1:0] {
      SLOT_REG, SLOT_FIRST, SLOT_SECOND
   } slot_type;

   state_type state_ff, state_in;
   slot_type  slot_ff, slot_in;

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      cmd.uop  = U_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.uop  = U_ACCEPT;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.func)
               FN_WRITE_IMM: begin
                  cmd.uop  = U_IMM;
                  state_in = S_FINISH;
               end
               FN_CONS: begin
                  if (sts.full) begin
                     state_in = S_GC_INIT;
                  end else begin
                     cmd.uop  = U_RD_A;
                     state_in = S_A;
                  end
               end
               FN_COLLECT: state_in = S_GC_INIT;
               default: begin
                  if (sts.func inside {FN_COPY, FN_CAR, FN_CDR, FN_SET_CAR, FN_SET_CDR,
                                       FN_READ}) begin
                     cmd.uop  = U_RD_A;
                     state_in = S_A;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
            endcase
         end
         S_A: begin
            case (sts.func)
               FN_COPY, FN_READ: begin
                  cmd.uop  = U_COPY;
                  state_in = S_FINISH;
               end
               FN_CAR, FN_CDR: begin
                  cmd.uop  = U_CAR_RD;
                  state_in = sts.rd_pair ? S_CAR_WB : S_FINISH;
               end
               default: begin
                  cmd.uop  = U_RD_B;
                  state_in = S_B;
               end
            endcase
         end
         S_B: begin
            cmd.uop  = (sts.func == FN_CONS) ? U_CONS : U_SET;
            state_in = S_FINISH;
         end
         S_CAR_WB: begin
            cmd.uop  = U_CAR_WB;
            state_in = S_FINISH;
         end
         S_GC_INIT: begin
            cmd.uop  = U_GC_INIT;
            state_in = S_GC_NEXT;
         end
         S_GC_NEXT: begin
            if (sts.scan_regs) begin
               cmd.uop  = U_GC_RDREG;
               state_in = S_GC_LDREG;
            end else if (!sts.scan_done) begin
               cmd.uop  = U_GC_RDCELL;
               state_in = S_GC_LDCELL;
            end else begin
               cmd.uop  = U_GC_FLIP;
               state_in = S_AFTER_GC;
            end
         end
         S_GC_LDREG: begin
            cmd.uop  = U_GC_LDREG;
            slot_in  = SLOT_REG;
            state_in = S_F_CHK;
         end
         S_GC_LDCELL: begin
            cmd.uop  = U_GC_LDCELL;
            slot_in  = SLOT_FIRST;
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            cmd.uop  = U_F_RD;
            state_in = sts.a_pair ? S_F_EVAL : S_WB;
         end
         S_F_EVAL: begin
            cmd.uop  = U_F_EVAL;
            state_in = (sts.broken || sts.full) ? S_WB : S_F_MARK;
         end
         S_F_MARK: begin
            cmd.uop  = U_F_MARK;
            state_in = S_WB;
         end
         S_WB: begin
            case (slot_ff)
               SLOT_FIRST: begin
                  cmd.uop  = U_WB_FIRST;
                  slot_in  = SLOT_SECOND;
                  state_in = S_F_CHK;
               end
               SLOT_SECOND: begin
                  cmd.uop  = U_WB_SECOND;
                  state_in = S_GC_NEXT;
               end
               default: begin
                  cmd.uop  = U_WB_REG;
                  state_in = S_GC_NEXT;
               end
            endcase
         end
         S_AFTER_GC: begin
            if (sts.full) begin
               cmd.uop  = U_FULL;
               state_in = S_FINISH;
            end else if (sts.func == FN_CONS) begin
               cmd.uop  = U_RD_A;
               state_in = S_A;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.uop  = U_DONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         slot_ff  <= SLOT_REG;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

FILE: design/ccgc_dp.sv
module ccgc_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ccgc_pkg::cmd_type                    cmd,
   output ccgc_pkg::sts_type                    sts,
   input  logic [ccgc_pkg::FUNC_W-1:0]          req_func,
   input  logic [ccgc_pkg::RNUM_W-1:0]          req_dest_reg,
   input  logic [ccgc_pkg::RNUM_W-1:0]          req_src_a_reg,
   input  logic [ccgc_pkg::RNUM_W-1:0]          req_src_b_reg,
   input  logic [ccgc_pkg::TAG_W-1:0]           req_imm_tag,
   input  logic [ccgc_pkg::PAY_W-1:0]           req_imm_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ccgc_pkg::TAG_W-1:0]           rsp_value_tag,
   output logic [ccgc_pkg::PAY_W-1:0]           rsp_value_payload,
   output logic [ccgc_pkg::STAT_W-1:0]          rsp_status,
   output logic [ccgc_pkg::CELLS_W-1:0]         rsp_cells_used,
   output logic                                 rsp_gc_ran
);
   import ccgc_pkg::*;

   logic [FUNC_W-1:0] func_ff;
   logic [RNUM_W-1:0] dest_ff, sa_ff, sb_ff;
   logic [TAG_W-1:0]  itag_ff;
   logic [PAY_W-1:0]  ipay_ff;

   word_type           w_a_ff, w_a_in, w_b_ff, w_b_in;
   logic [CNT_W-1:0]   free_ff, free_in, scan_ff, scan_in;
   logic               space_ff, space_in;
   logic [REG_COUNT-1:0] valid_ff, valid_in;
   logic               rvalid_ff, rvalid_in;
   word_type           res_ff, res_in;
   logic [STAT_W-1:0]  stat_ff, stat_in;
   logic               gc_ff, gc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   word_type           rsp_word_ff;
   logic [STAT_W-1:0]  rsp_stat_ff;
   logic [CELLS_W-1:0] rsp_cells_ff;
   logic               rsp_gc_ff;

   logic               reg_we, reg_rok;
   logic [REG_W-1:0]   reg_waddr, reg_raddr;
   word_type           reg_wdata;
   logic [WORD_W-1:0]  reg_rdata;
   word_type           regword;

   logic               first_we, second_we;
   logic [ADDR_W-1:0]  first_waddr, second_waddr, mem_raddr;
   word_type           first_wdata, second_wdata;
   logic [WORD_W-1:0]  first_rdata, second_rdata;
   word_type           first_rd, second_rd;

   logic               is_set, imm_ok, full;
   logic [IDX_W-1:0]   free_idx, scan_idx;
   word_type           imm_word, broken_word;

   assign regword   = rvalid_ff ? word_type'(reg_rdata) : '0;
   assign first_rd  = first_rdata;
   assign second_rd = second_rdata;

   assign is_set   = (func_ff == FN_SET_CAR) || (func_ff == FN_SET_CDR);
   assign imm_ok   = (itag_ff <= TAG_MAX) && !(itag_ff inside {TAG_PAIR, TAG_BROKEN});
   assign full     = free_ff >= CNT_W'(MEM_DEPTH);
   assign free_idx = free_ff[IDX_W-1:0];
   assign scan_idx = scan_ff[IDX_W-1:0];

   always_comb begin
      imm_word.tag    = itag_ff;
      imm_word.pay    = ipay_ff;
      broken_word.tag = TAG_BROKEN;
      broken_word.pay = '0;
   end

   always_comb begin
      w_a_in       = w_a_ff;
      w_b_in       = w_b_ff;
      free_in      = free_ff;
      scan_in      = scan_ff;
      space_in     = space_ff;
      valid_in     = valid_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      gc_in        = gc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      reg_we       = 1'b0;
      reg_waddr    = reg_idx(dest_ff);
      reg_wdata    = regword;
      reg_raddr    = reg_idx(sa_ff);
      reg_rok      = reg_ok(sa_ff);

      first_we     = 1'b0;
      second_we    = 1'b0;
      first_waddr  = {~space_ff, free_idx};
      second_waddr = {~space_ff, free_idx};
      first_wdata  = first_rd;
      second_wdata = second_rd;
      mem_raddr    = {space_ff, cell_idx(w_a_ff.pay)};

      case (cmd.uop)
         U_ACCEPT: begin
            res_in  = '0;
            stat_in = ST_OK;
            gc_in   = 1'b0;
         end
         U_IMM: begin
            if (imm_ok) begin
               reg_we    = reg_ok(dest_ff);
               reg_wdata = imm_word;
               res_in    = imm_word;
            end else begin
               stat_in = ST_BAD_IMM;
            end
         end
         U_RD_A: begin
            reg_raddr = is_set ? reg_idx(dest_ff) : reg_idx(sa_ff);
            reg_rok   = is_set ? reg_ok(dest_ff) : reg_ok(sa_ff);
         end
         U_RD_B: begin
            w_a_in    = regword;
            reg_raddr = is_set ? reg_idx(sa_ff) : reg_idx(sb_ff);
            reg_rok   = is_set ? reg_ok(sa_ff) : reg_ok(sb_ff);
         end
         U_COPY: begin
            res_in = regword;
            reg_we = (func_ff == FN_COPY) && reg_ok(dest_ff);
         end
         U_CAR_RD: begin
            w_a_in    = regword;
            mem_raddr = {space_ff, cell_idx(regword.pay)};
            if (!is_pair(regword)) begin
               stat_in = ST_NOT_PAIR;
            end
         end
         U_CAR_WB: begin
            reg_wdata = (func_ff == FN_CAR) ? first_rd : second_rd;
            reg_we    = reg_ok(dest_ff);
            res_in    = reg_wdata;
         end
         U_SET: begin
            if (is_pair(w_a_ff)) begin
               res_in       = regword;
               first_we     = (func_ff == FN_SET_CAR);
               second_we    = (func_ff == FN_SET_CDR);
               first_waddr  = {space_ff, cell_idx(w_a_ff.pay)};
               second_waddr = {space_ff, cell_idx(w_a_ff.pay)};
               first_wdata  = regword;
               second_wdata = regword;
            end else begin
               stat_in = ST_NOT_PAIR;
            end
         end
         U_CONS: begin
            first_we     = 1'b1;
            second_we    = 1'b1;
            first_waddr  = {space_ff, free_idx};
            second_waddr = {space_ff, free_idx};
            first_wdata  = w_a_ff;
            second_wdata = regword;
            reg_we       = reg_ok(dest_ff);
            reg_wdata    = pair_word(free_ff);
            res_in       = pair_word(free_ff);
            free_in      = free_ff + 1'b1;
         end
         U_FULL: stat_in = ST_NO_MEM;
         U_GC_INIT: begin
            free_in = CNT_W'(REG_COUNT);
            scan_in = '0;
            gc_in   = 1'b1;
         end
         U_GC_RDREG: begin
            reg_raddr = scan_ff[REG_W-1:0];
            reg_rok   = 1'b1;
         end
         U_GC_LDREG: w_a_in = regword;
         U_GC_RDCELL: mem_raddr = {~space_ff, scan_idx};
         U_GC_LDCELL: begin
            w_a_in = first_rd;
            w_b_in = second_rd;
         end
         U_F_RD: mem_raddr = {space_ff, cell_idx(w_a_ff.pay)};
         U_F_EVAL: begin
            // broken heart: take the forwarding pair; else evacuate to to-space unless it is full
            if (first_rd.tag == TAG_BROKEN) begin
               w_a_in = second_rd;
            end else if (!full) begin
               first_we  = 1'b1;
               second_we = 1'b1;
            end
         end
         U_F_MARK: begin
            first_we     = 1'b1;
            second_we    = 1'b1;
            first_waddr  = {space_ff, cell_idx(w_a_ff.pay)};
            second_waddr = {space_ff, cell_idx(w_a_ff.pay)};
            first_wdata  = broken_word;
            second_wdata = pair_word(free_ff);
            w_a_in       = pair_word(free_ff);
            free_in      = free_ff + 1'b1;
         end
         U_WB_REG: begin
            reg_we    = 1'b1;
            reg_waddr = scan_ff[REG_W-1:0];
            reg_wdata = w_a_ff;
            scan_in   = scan_ff + 1'b1;
         end
         U_WB_FIRST: begin
            first_we    = 1'b1;
            first_waddr = {~space_ff, scan_idx};
            first_wdata = w_a_ff;
            w_a_in      = w_b_ff;
         end
         U_WB_SECOND: begin
            second_we    = 1'b1;
            second_waddr = {~space_ff, scan_idx};
            second_wdata = w_a_ff;
            scan_in      = scan_ff + 1'b1;
         end
         U_GC_FLIP: space_in = ~space_ff;
         U_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase

      if (reg_we) begin
         valid_in[reg_waddr] = 1'b1;
      end
      rvalid_in = reg_rok && valid_ff[reg_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= CNT_W'(REG_COUNT);
         scan_ff      <= '0;
         space_ff     <= 1'b0;
         valid_ff     <= '0;
         rvalid_ff    <= 1'b0;
         stat_ff      <= ST_OK;
         gc_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_ff      <= free_in;
         scan_ff      <= scan_in;
         space_ff     <= space_in;
         valid_ff     <= valid_in;
         rvalid_ff    <= rvalid_in;
         stat_ff      <= stat_in;
         gc_ff        <= gc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_a_ff <= w_a_in;
      w_b_ff <= w_b_in;
      res_ff <= res_in;
      if (cmd.uop == U_ACCEPT) begin
         func_ff <= req_func;
         dest_ff <= req_dest_reg;
         sa_ff   <= req_src_a_reg;
         sb_ff   <= req_src_b_reg;
         itag_ff <= req_imm_tag;
         ipay_ff <= req_imm_payload;
      end
      if (cmd.uop == U_DONE) begin
         rsp_word_ff  <= res_ff;
         rsp_stat_ff  <= stat_ff;
         rsp_cells_ff <= cells_of(free_ff);
         rsp_gc_ff    <= gc_ff;
      end
   end

   ccgc_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_reg_ram (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (reg_waddr),
      .wr_data (reg_wdata),
      .rd_addr (reg_raddr),
      .rd_data (reg_rdata)
   );

   ccgc_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_first_ram (
      .clock   (clock),
      .wr_en   (first_we),
      .wr_addr (first_waddr),
      .wr_data (first_wdata),
      .rd_addr (mem_raddr),
      .rd_data (first_rdata)
   );

   ccgc_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_second_ram (
      .clock   (clock),
      .wr_en   (second_we),
      .wr_addr (second_waddr),
      .wr_data (second_wdata),
      .rd_addr (mem_raddr),
      .rd_data (second_rdata)
   );

   always_comb begin
      sts.func      = func_ff;
      sts.rd_pair   = is_pair(regword);
      sts.a_pair    = is_pair(w_a_ff);
      sts.broken    = (first_rd.tag == TAG_BROKEN);
      sts.full      = full;
      sts.scan_regs = scan_ff < CNT_W'(REG_COUNT);
      sts.scan_done = scan_ff >= free_ff;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value_tag     = rsp_word_ff.tag;
   assign rsp_value_payload = rsp_word_ff.pay;
   assign rsp_status        = rsp_stat_ff;
   assign rsp_cells_used    = rsp_cells_ff;
   assign rsp_gc_ran        = rsp_gc_ff;

endmodule
